// File: hw/rtl/go_back_n_send_window_macros.svh
// Assertion macros for the go-back-N send window checker.
// Used by go_back_n_send_window_checker.sv; depends on nothing else.
`ifndef GO_BACK_N_SEND_WINDOW_MACROS_SVH
`define GO_BACK_N_SEND_WINDOW_MACROS_SVH

// same-cycle implication
`define GBN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("go_back_n_send_window: same-cycle check failed");

// next-cycle implication
`define GBN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("go_back_n_send_window: next-cycle check failed");

`endif

// File: hw/rtl/gbn_sw_pkg.sv
// Shared types and constants of the go-back-N send window.
// No dependencies; imported by go_back_n_send_window and its checker.
`timescale 1ns / 1ps
`default_nettype none

package gbn_sw_pkg;

   localparam int unsigned CountWidth  = 11;
   localparam int unsigned IndexWidth  = 10;
   localparam int unsigned WindowWidth = 7;
   localparam int unsigned RunWidth    = 6;

   typedef logic [CountWidth-1:0]  count_type;
   typedef logic [IndexWidth-1:0]  index_type;
   typedef logic [WindowWidth-1:0] window_type;
   typedef logic [RunWidth-1:0]    run_type;
   typedef logic [1:0]             kind_type;
   typedef logic                   csr_index_type;

   localparam count_type  MaxPackets = 11'd1024;
   localparam window_type MaxWindow  = 7'd64;
   localparam window_type MinWindow  = 7'd2;
   localparam run_type    RunLimit   = 6'd63;

   localparam kind_type KindStart   = 2'd0;
   localparam kind_type KindAck     = 2'd1;
   localparam kind_type KindTimeout = 2'd2;

   localparam csr_index_type RegWindowSize  = 1'b0;
   localparam csr_index_type RegPacketCount = 1'b1;

   localparam window_type WindowSizeReset  = 7'd5;
   localparam count_type  PacketCountReset = 11'd0;

   typedef enum logic [2:0] {
      StIdle = 3'b001,
      StEval = 3'b010,
      StRun  = 3'b100
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/go_back_n_send_window.sv
// Go-back-N sender window controller: event in, a run of send-order words out.
// Depends on gbn_sw_pkg.
//
// Each accepted event word first goes through window evaluation, then the run
// sequencer emits one send-order word per cycle through the output register while
// rsp_ready allows it, from the shared next-index incrementer and the window-end
// comparators. An event yields 1 to 63 words; req_ready rises again once the last
// word of the run is loaded into the output register, so the next event may be
// taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_send_window (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  gbn_sw_pkg::kind_type  req_kind,
   input  wire  gbn_sw_pkg::count_type req_ack_number,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic                       rsp_send_valid,
   output gbn_sw_pkg::index_type      rsp_send_index,
   output logic                       rsp_last_of_run,
   output logic                       rsp_transfer_done,
   input  wire                        csr_wen,
   input  wire  gbn_sw_pkg::csr_index_type csr_index,
   input  wire  gbn_sw_pkg::count_type csr_wdata
);
   import gbn_sw_pkg::*;

   state_type  state_ff, state_in;
   window_type window_size_ff;
   count_type  packet_count_ff;
   kind_type   kind_ff;
   count_type  ack_ff;
   count_type  base_ff, base_in;
   count_type  next_ff, next_in;
   count_type  end_ff, end_in;
   logic       active_ff, active_in;
   logic       run_ff, run_in;
   run_type    k_ff, k_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_send_valid_ff, rsp_send_valid_in;
   index_type  rsp_send_index_ff, rsp_send_index_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_done_ff, rsp_done_in;

   count_type  cnt;
   window_type win_eff;
   count_type  win_last;
   count_type  ack_sat;
   count_type  end_clamp;
   count_type  diff;
   logic [CountWidth:0] grow;
   count_type  next_plus;
   logic       out_free;
   logic       send_ok;
   logic       last_word;
   logic       done;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff  <= WindowSizeReset;
         packet_count_ff <= PacketCountReset;
      end else if (csr_wen) begin
         case (csr_index)
            RegWindowSize:  window_size_ff  <= csr_wdata[WindowWidth-1:0];
            RegPacketCount: packet_count_ff <= csr_wdata;
            default:        packet_count_ff <= packet_count_ff;
         endcase
      end
   end

   always_comb begin
      cnt      = (packet_count_ff > MaxPackets) ? MaxPackets : packet_count_ff;
      win_eff  = window_size_ff;
      if (win_eff < MinWindow) win_eff = MinWindow;
      if (win_eff > MaxWindow) win_eff = MaxWindow;
      win_last = CountWidth'(win_eff - 7'd1);
      ack_sat   = (ack_ff > cnt) ? cnt : ack_ff;
      end_clamp = (end_ff > cnt) ? cnt : end_ff;
      diff      = ack_sat - base_ff;
      grow      = {1'b0, end_clamp} + {1'b0, diff};
      next_plus = next_ff + 11'd1;
      out_free  = !rsp_valid_ff || rsp_ready;
      send_ok   = run_ff && (next_ff < end_ff) && (k_ff < RunLimit);
      last_word = !((next_plus < end_ff) && (k_ff < RunLimit - 6'd1));
      done      = !active_ff && (base_ff >= cnt);
   end

   always_comb begin
      state_in          = state_ff;
      base_in           = base_ff;
      next_in           = next_ff;
      end_in            = end_ff;
      active_in         = active_ff;
      run_in            = run_ff;
      k_in              = k_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_send_valid_in = rsp_send_valid_ff;
      rsp_send_index_in = rsp_send_index_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_done_in       = rsp_done_ff;
      case (state_ff)
         StIdle: begin
            if (req_valid) state_in = StEval;
         end
         StEval: begin
            run_in   = 1'b0;
            k_in     = '0;
            state_in = StRun;
            if (kind_ff == KindStart) begin
               base_in   = '0;
               next_in   = '0;
               end_in    = (win_last > cnt) ? cnt : win_last;
               active_in = (cnt != '0);
               run_in    = 1'b1;
            end else if ((kind_ff == KindAck || kind_ff == KindTimeout) && active_ff) begin
               end_in = end_clamp;
               if (base_ff >= cnt) begin
                  active_in = 1'b0;
               end else if (kind_ff == KindAck) begin
                  if (ack_sat > base_ff) begin
                     base_in   = ack_sat;
                     end_in    = (grow > {1'b0, cnt}) ? cnt : grow[CountWidth-1:0];
                     next_in   = (next_ff < ack_sat) ? ack_sat : next_ff;
                     active_in = (ack_sat < cnt);
                     run_in    = 1'b1;
                  end
               end else begin
                  next_in = base_ff;
                  run_in  = 1'b1;
               end
            end
         end
         StRun: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_done_in  = done;
               if (send_ok) begin
                  rsp_send_valid_in = 1'b1;
                  rsp_send_index_in = next_ff[IndexWidth-1:0];
                  rsp_last_in       = last_word;
                  next_in           = next_plus;
                  k_in              = k_ff + 6'd1;
                  if (last_word) state_in = StIdle;
               end else begin
                  rsp_send_valid_in = 1'b0;
                  rsp_send_index_in = '0;
                  rsp_last_in       = 1'b1;
                  state_in          = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         base_ff      <= '0;
         next_ff      <= '0;
         end_ff       <= '0;
         active_ff    <= 1'b0;
         run_ff       <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         end_ff       <= end_in;
         active_ff    <= active_in;
         run_ff       <= run_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff <= req_kind;
         ack_ff  <= req_ack_number;
      end
      rsp_send_valid_ff <= rsp_send_valid_in;
      rsp_send_index_ff <= rsp_send_index_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_done_ff       <= rsp_done_in;
   end

   assign req_ready         = (state_ff == StIdle);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_valid    = rsp_send_valid_ff;
   assign rsp_send_index    = rsp_send_index_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_transfer_done = rsp_done_ff;

endmodule

`default_nettype wire

// File: hw/rtl/go_back_n_send_window_checker.sv
// Port-level checks of the go-back-N send window, bound to the top level.
// Depends on gbn_sw_pkg and go_back_n_send_window_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module gbn_sw_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_valid,
   input wire                        req_ready,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input wire                        rsp_send_valid,
   input wire gbn_sw_pkg::index_type rsp_send_index,
   input wire                        rsp_last_of_run,
   input wire                        rsp_transfer_done
);
   import gbn_sw_pkg::*;

`include "go_back_n_send_window_macros.svh"

   `GBN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_send_valid) && $stable(rsp_send_index) && $stable(rsp_last_of_run) && $stable(rsp_transfer_done))
   `GBN_ASSERT_NOW(a_null_word, clock, reset, rsp_valid && !rsp_send_valid, rsp_last_of_run && (rsp_send_index == '0))
   `GBN_ASSERT_NEXT(a_run_step, clock, reset, rsp_valid && rsp_ready && rsp_send_valid && !rsp_last_of_run, rsp_valid && rsp_send_valid && (rsp_send_index == IndexWidth'($past(rsp_send_index) + 10'd1)))
   `GBN_ASSERT_NEXT(a_busy_after_event, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind go_back_n_send_window gbn_sw_checker u_gbn_sw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_send_valid    (rsp_send_valid),
   .rsp_send_index    (rsp_send_index),
   .rsp_last_of_run   (rsp_last_of_run),
   .rsp_transfer_done (rsp_transfer_done)
);

`default_nettype wire
